>>> sv/cwh_pkg.sv
// Shared types and constants for the calibrated wetness hysteresis block.
`default_nettype none
package cwh_pkg;

	localparam int RAW_MAX  = 4095;
	localparam int PCT_FULL = 100;
	localparam int RAW_W    = 12;
	localparam int PCT_W    = 7;
	localparam int THR_W    = 8;
	// dividend width: enough for 4095 * 100
	localparam int DIV_W    = 19;
	localparam int DCNT_W   = 5;

	localparam logic [2:0] REG_DRY_POINT     = 3'd0;
	localparam logic [2:0] REG_WET_POINT     = 3'd1;
	localparam logic [2:0] REG_ON_THRESHOLD  = 3'd2;
	localparam logic [2:0] REG_OFF_THRESHOLD = 3'd3;
	localparam logic [2:0] REG_HYST_ENABLE   = 3'd4;

	typedef struct packed {
		logic [RAW_W-1:0] dry_point;
		logic [RAW_W-1:0] wet_point;
		logic [THR_W-1:0] on_threshold;
		logic [THR_W-1:0] off_threshold;
		logic             hysteresis_enable;
	} cwh_cfg_t;

endpackage
`default_nettype wire

>>> sv/cwh_front.sv
// Front end: accepts samples, accumulates a measurement, queues finished or aborted ones.
`default_nettype none
module cwh_front import cwh_pkg::*; #(
	parameter int SAMPLES_PER_MEASUREMENT = 5,
	parameter int SUM_W = 15
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [RAW_W-1:0] sample_value,
	input  wire logic             conversion_ok,
	input  wire logic             q_full,
	output logic                  q_push,
	output logic [SUM_W:0]        q_data
);
	localparam int CNT_W = (SAMPLES_PER_MEASUREMENT > 1) ? $clog2(SAMPLES_PER_MEASUREMENT) : 1;

	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] acc;
	logic             last;
	logic             accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign acc      = sum_q + SUM_W'(sample_value);
	assign last     = (count_q == CNT_W'(SAMPLES_PER_MEASUREMENT - 1));
	assign q_push   = accept && (!conversion_ok || last);
	assign q_data   = {conversion_ok, conversion_ok ? acc : '0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (accept) begin
			if (!conversion_ok || last) begin
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				count_q <= count_q + 1'b1;
				sum_q   <= acc;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/cwh_fifo.sv
// Two-entry queue between the front and back ends.
`default_nettype none
module cwh_fifo #(
	parameter int WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  valid,
	output logic [WIDTH-1:0]      data
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       fill_q;

	assign full  = (fill_q == 2'd2);
	assign valid = (fill_q != 2'd0);
	assign data  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/cwh_back.sv
// Back end: reciprocal multiply for the average, serial divider for the percent, rain decision, output register.
`default_nettype none
module cwh_back import cwh_pkg::*; #(
	parameter int SAMPLES_PER_MEASUREMENT = 5,
	parameter int SUM_W = 15
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cwh_cfg_t         cfg,
	input  wire logic             q_valid,
	input  wire logic [SUM_W:0]   q_data,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [RAW_W-1:0]      average_raw,
	output logic [PCT_W-1:0]      wet_percent,
	output logic                  raining,
	output logic                  measurement_ok
);
	// ceil(2^AVG_SH / N) gives the exact quotient for every sum below 2^SUM_W
	localparam int AVG_SH = SUM_W + $clog2(SAMPLES_PER_MEASUREMENT);
	localparam int AVG_MW = AVG_SH + 1;
	localparam int PROD_W = SUM_W + AVG_MW;
	localparam logic [AVG_MW-1:0] AVG_MUL = AVG_MW'(((longint'(1) << AVG_SH)
		+ longint'(SAMPLES_PER_MEASUREMENT) - 1) / longint'(SAMPLES_PER_MEASUREMENT));

	typedef enum logic [2:0] {S_IDLE, S_AVG, S_MAP, S_PCT, S_CLAMP, S_DECIDE} state_t;

	state_t             state_q;
	logic [DCNT_W-1:0]  cnt_q;
	logic [DIV_W-1:0]   dvd_q;
	logic [RAW_W-1:0]   rem_q;
	logic [RAW_W-1:0]   dvs_q;
	logic [RAW_W-1:0]   avg_q;
	logic [PCT_W-1:0]   pct_q;
	logic               ok_q;
	logic               flag_q;

	logic [RAW_W:0]     tmp;
	logic [RAW_W:0]     diff;
	logic               ge;
	logic               step_done;
	logic [PROD_W-1:0]  avg_prod;
	logic [RAW_W-1:0]   avg_c;
	logic               zero_pct;
	logic [RAW_W-1:0]   num;
	logic [RAW_W-1:0]   den;
	logic [PCT_W-1:0]   on_c;
	logic [PCT_W-1:0]   off_c;
	logic [PCT_W-1:0]   hi_t;
	logic [PCT_W-1:0]   lo_t;
	logic               next_flag;
	logic               room;
	logic               load;

	assign tmp       = {rem_q, dvd_q[DIV_W-1]};
	assign ge        = (tmp >= {1'b0, dvs_q});
	assign diff      = tmp - {1'b0, dvs_q};
	assign step_done = (cnt_q == DCNT_W'(DIV_W - 1));
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign room      = !out_valid || out_ready;
	assign load      = (state_q == S_DECIDE) && room;
	assign avg_prod  = PROD_W'(dvd_q[SUM_W-1:0]) * PROD_W'(AVG_MUL);
	assign avg_c     = (dvd_q > DIV_W'(RAW_MAX)) ? RAW_W'(RAW_MAX) : dvd_q[RAW_W-1:0];

	always_comb begin
		zero_pct = 1'b0;
		num      = '0;
		den      = '0;
		if (cfg.dry_point == cfg.wet_point) begin
			zero_pct = 1'b1;
		end else if (cfg.wet_point > cfg.dry_point) begin
			zero_pct = (avg_c <= cfg.dry_point);
			num      = avg_c - cfg.dry_point;
			den      = cfg.wet_point - cfg.dry_point;
		end else begin
			zero_pct = (avg_c >= cfg.dry_point);
			num      = cfg.dry_point - avg_c;
			den      = cfg.dry_point - cfg.wet_point;
		end
	end

	always_comb begin
		on_c  = (cfg.on_threshold > THR_W'(PCT_FULL)) ? PCT_W'(PCT_FULL)
			: cfg.on_threshold[PCT_W-1:0];
		off_c = (cfg.off_threshold > THR_W'(PCT_FULL)) ? PCT_W'(PCT_FULL)
			: cfg.off_threshold[PCT_W-1:0];
		hi_t  = (on_c < off_c) ? off_c : on_c;
		lo_t  = (on_c < off_c) ? on_c : off_c;
		if (!cfg.hysteresis_enable) begin
			next_flag = (pct_q >= on_c);
		end else if (!flag_q) begin
			next_flag = (pct_q >= hi_t);
		end else begin
			next_flag = !(pct_q <= lo_t);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			flag_q         <= 1'b0;
			ok_q           <= 1'b0;
			out_valid      <= 1'b0;
			dvd_q          <= '0;
			rem_q          <= '0;
			dvs_q          <= '0;
			avg_q          <= '0;
			pct_q          <= '0;
			average_raw    <= '0;
			wet_percent    <= '0;
			raining        <= 1'b0;
			measurement_ok <= 1'b0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						ok_q <= q_data[SUM_W];
						if (q_data[SUM_W]) begin
							dvd_q   <= DIV_W'(q_data[SUM_W-1:0]);
							state_q <= S_AVG;
						end else begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_AVG: begin
					dvd_q   <= DIV_W'(avg_prod[AVG_SH +: SUM_W]);
					state_q <= S_MAP;
				end
				S_PCT: begin
					rem_q <= ge ? diff[RAW_W-1:0] : tmp[RAW_W-1:0];
					dvd_q <= {dvd_q[DIV_W-2:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (step_done) begin
						state_q <= S_CLAMP;
					end
				end
				S_MAP: begin
					avg_q <= avg_c;
					if (zero_pct) begin
						pct_q   <= '0;
						state_q <= S_DECIDE;
					end else begin
						dvd_q   <= DIV_W'(num) * DIV_W'(PCT_FULL);
						rem_q   <= '0;
						dvs_q   <= den;
						cnt_q   <= '0;
						state_q <= S_PCT;
					end
				end
				S_CLAMP: begin
					pct_q   <= (dvd_q > DIV_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : dvd_q[PCT_W-1:0];
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (room) begin
						average_raw    <= ok_q ? avg_q : '0;
						wet_percent    <= ok_q ? pct_q : '0;
						raining        <= ok_q ? next_flag : flag_q;
						flag_q         <= ok_q ? next_flag : flag_q;
						measurement_ok <= ok_q;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> sv/calibrated_wetness_hysteresis_core.sv
// Top level: averaged ADC samples mapped to wetness percent with rain hysteresis.
// Usage:
//   Slave stream (s_*) takes one ADC sample per word: s_tdata[11:0] is the
//   sample, s_tuser is the conversion-ok flag. Samples are summed in the front
//   end; the last sample of a measurement, or a failed conversion, queues one
//   job in a two-entry queue. A good sample that is not the last gives no word.
//   Master stream (m_*) gives one word per job: average, percent, rain flag in
//   m_tdata, measurement-ok in m_tuser.
//   Processing: a completed measurement goes through a reciprocal multiply
//   for the average and a 19-step serial divide for the percent before
//   m_tvalid rises; the divide is skipped when the reading is outside the
//   span toward dry or the points are equal, and both for an aborted one.
//   The back end handles one job at a time and takes a new one only after
//   the last is loaded into the output register; the serial divide is its longest step.
//   The front end keeps taking samples while the queue has room, so a stalled
//   receiver holds the output register and then backs up through the queue.
//   Reset clears the sum, count and rain flag and loads the calibration
//   registers with their defaults. Configuration goes through the APB port.
`default_nettype none
module calibrated_wetness_hysteresis_core import cwh_pkg::*; #(
	parameter int SAMPLES_PER_MEASUREMENT = 5
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [11:0] sample_value, [15:12] zero
	input  wire logic        s_tuser,   // [0] conversion_ok
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [11:0] average_raw, [18:12] wet_percent,
	                                    // [19] raining, [23:20] zero
	output logic             m_tuser,   // [0] measurement_ok
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int SUM_W = $clog2(SAMPLES_PER_MEASUREMENT * RAW_MAX + 1);

	cwh_cfg_t           cfg_q;
	logic [2:0]         reg_idx;
	logic               q_full;
	logic               q_push;
	logic [SUM_W:0]     q_wdata;
	logic               q_valid;
	logic [SUM_W:0]     q_rdata;
	logic               q_pop;
	logic [RAW_W-1:0]   average_raw;
	logic [PCT_W-1:0]   wet_percent;
	logic               raining;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dry_point         <= RAW_W'(3500);
			cfg_q.wet_point         <= RAW_W'(1500);
			cfg_q.on_threshold      <= THR_W'(60);
			cfg_q.off_threshold     <= THR_W'(45);
			cfg_q.hysteresis_enable <= 1'b1;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_DRY_POINT:     cfg_q.dry_point         <= pwdata[RAW_W-1:0];
				REG_WET_POINT:     cfg_q.wet_point         <= pwdata[RAW_W-1:0];
				REG_ON_THRESHOLD:  cfg_q.on_threshold      <= pwdata[THR_W-1:0];
				REG_OFF_THRESHOLD: cfg_q.off_threshold     <= pwdata[THR_W-1:0];
				REG_HYST_ENABLE:   cfg_q.hysteresis_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DRY_POINT:     prdata = 32'(cfg_q.dry_point);
			REG_WET_POINT:     prdata = 32'(cfg_q.wet_point);
			REG_ON_THRESHOLD:  prdata = 32'(cfg_q.on_threshold);
			REG_OFF_THRESHOLD: prdata = 32'(cfg_q.off_threshold);
			REG_HYST_ENABLE:   prdata = 32'(cfg_q.hysteresis_enable);
			default:           prdata = '0;
		endcase
	end

	cwh_front #(
		.SAMPLES_PER_MEASUREMENT(SAMPLES_PER_MEASUREMENT),
		.SUM_W(SUM_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.sample_value(s_tdata[RAW_W-1:0]),
		.conversion_ok(s_tuser),
		.q_full(q_full),
		.q_push(q_push),
		.q_data(q_wdata)
	);

	cwh_fifo #(
		.WIDTH(SUM_W + 1)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_wdata),
		.full(q_full),
		.pop(q_pop),
		.valid(q_valid),
		.data(q_rdata)
	);

	cwh_back #(
		.SAMPLES_PER_MEASUREMENT(SAMPLES_PER_MEASUREMENT),
		.SUM_W(SUM_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_data(q_rdata),
		.q_pop(q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.average_raw(average_raw),
		.wet_percent(wet_percent),
		.raining(raining),
		.measurement_ok(m_tuser)
	);

	assign m_tdata = {4'b0000, raining, wet_percent, average_raw};

endmodule
`default_nettype wire

>>> verif/tb_calibrated_wetness_hysteresis_core.sv
`timescale 1ns / 1ps
// Testbench for the wetness core: stream driver and monitor, register writes, and a predictor.
module tb_calibrated_wetness_hysteresis_core import cwh_pkg::*; ();

	localparam int SAMPLES      = 5;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 1500;
	localparam int PHASE_ITEMS  = 130;
	localparam int NUM_PHASES   = 12;

	typedef struct packed {
		logic [RAW_W-1:0] value;
		logic             ok;
	} sample_t;

	typedef struct packed {
		logic [RAW_W-1:0] avg;
		logic [PCT_W-1:0] pct;
		logic             rain;
		logic             ok;
	} reading_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	sample_t     sample_q[$];
	reading_t    reading_q[$];
	cwh_cfg_t    cfg;
	logic [14:0] acc_sum;
	int          acc_count;
	logic        rain_state;
	int          mismatch_cnt = 0;
	int          tx_idle_pct  = 0;
	int          rx_idle_pct  = 0;
	logic        tx_pause     = 1'b0;
	int          hold_req     = 0;
	int          hold_seen    = 0;
	int          hold_left    = 0;
	logic        rx_hold      = 1'b0;

	calibrated_wetness_hysteresis_core #(
		.SAMPLES_PER_MEASUREMENT(SAMPLES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pct_clamp(logic [THR_W-1:0] t);
		return (int'(t) > PCT_FULL) ? PCT_FULL : int'(t);
	endfunction

	function automatic logic [PCT_W-1:0] wet_pct(logic [RAW_W-1:0] raw);
		int num;
		int den;
		int q;
		if (cfg.dry_point == cfg.wet_point)
			return '0;
		if (cfg.wet_point > cfg.dry_point) begin
			if (raw <= cfg.dry_point)
				return '0;
			num = int'(raw) - int'(cfg.dry_point);
			den = int'(cfg.wet_point) - int'(cfg.dry_point);
		end else begin
			if (raw >= cfg.dry_point)
				return '0;
			num = int'(cfg.dry_point) - int'(raw);
			den = int'(cfg.dry_point) - int'(cfg.wet_point);
		end
		q = num * PCT_FULL / den;
		if (q > PCT_FULL)
			q = PCT_FULL;
		return q[PCT_W-1:0];
	endfunction

	task automatic predict_reading(logic [RAW_W-1:0] value, logic ok);
		reading_t r;
		int avg;
		int on_t;
		int off_t;
		int tmp;
		r = '0;
		if (!ok) begin
			acc_sum   = '0;
			acc_count = 0;
			r.rain    = rain_state;
			reading_q.push_back(r);
			return;
		end
		acc_sum   = acc_sum + 15'(value);
		acc_count = acc_count + 1;
		if (acc_count < SAMPLES)
			return;
		avg = int'(acc_sum) / SAMPLES;
		if (avg > RAW_MAX)
			avg = RAW_MAX;
		acc_sum   = '0;
		acc_count = 0;
		r.avg = avg[RAW_W-1:0];
		r.pct = wet_pct(r.avg);
		on_t  = pct_clamp(cfg.on_threshold);
		off_t = pct_clamp(cfg.off_threshold);
		if (!cfg.hysteresis_enable) begin
			rain_state = (int'(r.pct) >= on_t);
		end else begin
			if (on_t < off_t) begin
				tmp   = on_t;
				on_t  = off_t;
				off_t = tmp;
			end
			if (!rain_state) begin
				if (int'(r.pct) >= on_t)
					rain_state = 1'b1;
			end else if (int'(r.pct) <= off_t) begin
				rain_state = 1'b0;
			end
		end
		r.rain = rain_state;
		r.ok   = 1'b1;
		reading_q.push_back(r);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// sender
	always @(posedge clk) begin : drive
		sample_t nxt;
		logic    take;
		if (arst_n) begin
			take = !s_tvalid;
			if (s_tvalid && s_tready) begin
				predict_reading(s_tdata[RAW_W-1:0], s_tuser);
				take = 1'b1;
			end
			if (take) begin
				if (sample_q.size() != 0 && !tx_pause &&
				    int'($urandom_range(99)) >= tx_idle_pct) begin
					nxt = sample_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= 16'(nxt.value);
					s_tuser  <= nxt.ok;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin : watch
		reading_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (reading_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: unexpected word, data %h ok %b", $time, m_tdata, m_tuser);
				end else begin
					want = reading_q.pop_front();
					check_field("average_raw", 32'(want.avg), 32'(m_tdata[11:0]));
					check_field("wet_percent", 32'(want.pct), 32'(m_tdata[18:12]));
					check_field("raining", 32'(want.rain), 32'(m_tdata[19]));
					check_field("measurement_ok", 32'(want.ok), 32'(m_tuser));
				end
			end
			m_tready <= !rx_hold && (int'($urandom_range(99)) >= rx_idle_pct);
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			rx_hold   <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rx_hold   <= (hold_left > 1);
		end
	end

	task automatic reg_write(int idx, int value);
		int w;
		logic [31:0] data;
		case (idx)
			REG_DRY_POINT, REG_WET_POINT:         w = RAW_W;
			REG_ON_THRESHOLD, REG_OFF_THRESHOLD:  w = THR_W;
			REG_HYST_ENABLE:                      w = 1;
			default:                              w = 0;
		endcase
		data = (w == 0) ? $urandom :
			(($urandom << w) | (32'(value) & ((32'd1 << w) - 32'd1)));
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 5'(idx * 4);
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_DRY_POINT:     cfg.dry_point         = data[RAW_W-1:0];
			REG_WET_POINT:     cfg.wet_point         = data[RAW_W-1:0];
			REG_ON_THRESHOLD:  cfg.on_threshold      = data[THR_W-1:0];
			REG_OFF_THRESHOLD: cfg.off_threshold     = data[THR_W-1:0];
			REG_HYST_ENABLE:   cfg.hysteresis_enable = data[0];
			default: ;
		endcase
	endtask

	task automatic settle();
		while (sample_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (reading_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_calibration(int dry, int wet, int on_t, int off_t, int hys);
		settle();
		reg_write(REG_DRY_POINT, dry);
		reg_write(REG_WET_POINT, wet);
		reg_write(REG_ON_THRESHOLD, on_t);
		reg_write(REG_OFF_THRESHOLD, off_t);
		reg_write(REG_HYST_ENABLE, hys);
	endtask

	task automatic queue_sample(int value, logic ok);
		sample_t it;
		it.value = value[RAW_W-1:0];
		it.ok    = ok;
		sample_q.push_back(it);
	endtask

	task automatic queue_measurement(int level, int spread);
		int v;
		for (int k = 0; k < SAMPLES; k++) begin
			v = level + int'($urandom_range(2 * spread)) - spread;
			if (v < 0)
				v = 0;
			if (v > RAW_MAX)
				v = RAW_MAX;
			queue_sample(v, 1'b1);
		end
	endtask

	// mostly whole measurements around the calibration span, plus aborts and noise
	task automatic random_phase(int items);
		int n;
		int kind;
		int t;
		int lvl;
		int cut;
		n = 0;
		while (n < items) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				t   = int'($urandom_range(140)) - 20;
				lvl = int'(cfg.dry_point) +
					(int'(cfg.wet_point) - int'(cfg.dry_point)) * t / 100;
				if ($urandom_range(3) == 0)
					lvl = $urandom_range(RAW_MAX);
				queue_measurement(lvl, ($urandom_range(3) == 0) ? 200 : 8);
				n += SAMPLES;
			end else if (kind < 85) begin
				cut = $urandom_range(SAMPLES - 1);
				for (int k = 0; k < cut; k++)
					queue_sample($urandom_range(RAW_MAX), 1'b1);
				queue_sample($urandom_range(RAW_MAX), 1'b0);
				n += cut + 1;
			end else if (kind < 93) begin
				queue_sample($urandom_range(RAW_MAX), 1'b0);
				n += 1;
			end else begin
				for (int k = 0; k < SAMPLES; k++)
					queue_sample($urandom_range(RAW_MAX), $urandom_range(15) != 0);
				n += SAMPLES;
			end
		end
	endtask

	initial begin
		cfg.dry_point         = 12'd3500;
		cfg.wet_point         = 12'd1500;
		cfg.on_threshold      = 8'd60;
		cfg.off_threshold     = 8'd45;
		cfg.hysteresis_enable = 1'b1;
		acc_sum    = '0;
		acc_count  = 0;
		rain_state = 1'b0;
		tx_idle_pct = 20;
		rx_idle_pct = 46;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset calibration: wet side saturates, dry side is zero, thresholds hit exactly
		queue_measurement(0, 0);
		queue_measurement(RAW_MAX, 0);
		queue_sample(RAW_MAX, 1'b1);
		queue_sample(RAW_MAX, 1'b1);
		queue_sample(RAW_MAX, 1'b0);
		queue_sample(0, 1'b0);
		queue_measurement(2300, 0);
		queue_measurement(2600, 0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: set_calibration(0, RAW_MAX, 60, 45, 1);
				1: set_calibration(RAW_MAX, 0, PCT_FULL, 0, 1);
				2: set_calibration(2000, 2000, 0, 0, 1);
				3: set_calibration(3000, 1000, 255, 255, 1);
				4: set_calibration(1000, 3000, 30, 80, 1);
				5: set_calibration(3500, 1500, 70, 20, 0);
				7: set_calibration(RAW_MAX, RAW_MAX, 0, 255, 0);
				default: set_calibration($urandom_range(RAW_MAX), $urandom_range(RAW_MAX),
					$urandom_range(255), $urandom_range(255), $urandom_range(1));
			endcase
			if (p == 0) begin
				for (int k = REG_HYST_ENABLE + 1; k < 8; k++)
					reg_write(k, 0);
			end
			if (p < 4) begin
				tx_idle_pct = 20;
				rx_idle_pct = 46;
			end else if (p < 8) begin
				tx_idle_pct = 46;
				rx_idle_pct = 20;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			random_phase(PHASE_ITEMS);
			if (p == 1) begin
				@(posedge clk);
				hold_req <= hold_req + 1;
			end
			if (p == 5) begin
				while (sample_q.size() > PHASE_ITEMS / 2)
					@(posedge clk);
				tx_pause <= 1'b1;
				@(posedge clk);
				while (reading_q.size() != 0)
					@(posedge clk);
				tx_pause <= 1'b0;
			end
		end

		settle();
		if (mismatch_cnt == 0 && reading_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
